@@ hdl/acbc_pkg.sv @@
// Package for the AES CBC block cipher core: sizes, S-box tables, round helpers.
// Used by the top-level core module; depends on nothing.
package acbc_pkg;

   localparam int KeyBitsDefault = 256;
   localparam int CsrIdxWidth    = 3;
   localparam int CsrDataWidth   = 64;

   localparam logic [CsrIdxWidth-1:0] CSR_KEY0   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY1   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY2   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY3   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_HI  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_LO  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_DECRYPT = 3'd6;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // byte b of the block sits at bits [127-8b -: 8]
   function automatic block_type enc_round(input block_type s, input logic last);
      block_type t, o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127-8*(c*4+r) -: 8] = sbox(s[127-8*(((c+r)%4)*4+r) -: 8]);
      o = t;
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[127-32*c -: 8];
            a1 = t[119-32*c -: 8];
            a2 = t[111-32*c -: 8];
            a3 = t[103-32*c -: 8];
            o[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
         end
      end
      return o;
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127-8*(((c+r)%4)*4+r) -: 8] = inv_sbox(s[127-8*(c*4+r) -: 8]);
      return t;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type o;
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r]  = s[127-32*c-8*r -: 8];
            x2[r] = xt(a[r]);
            x4[r] = xt(x2[r]);
            x8[r] = xt(x4[r]);
         end
         // rows use 14, 11, 13, 9 rotated
         for (int r = 0; r < 4; r++)
            o[127-32*c-8*r -: 8] =
               (x8[r] ^ x4[r] ^ x2[r]) ^
               (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
               (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
               (x8[(r+3)%4] ^ a[(r+3)%4]);
      end
      return o;
   endfunction

endpackage

@@ hdl/aes_cbc_block_cipher_core.sv @@
// Top level of the AES CBC block cipher core: key expansion, round loop, chaining.
// Depends on acbc_pkg and acbc_key_ram.
//
//  channel | direction | contents
//  req_    | in        | tdata {data_low, data_high}, tuser first_block
//  rsp_    | out       | tdata {result_low, result_high}
//  csr_    | in        | write-only register port, index 0..6
//
// Without first_block, an accepted block first primes the key RAM read. Each of
// the Nr+1 round key additions then needs two reads, because the 128-bit round
// key leaves the single 64-bit read port as two words. The result is then moved
// into the output register, where it becomes valid, and the core returns to idle
// to take the next block; a new block is not taken before that.
// A first_block transaction first copies the key into the key RAM and then
// expands it, one 32-bit word per cycle, until the 4*(Nr+1) words of the key
// schedule are stored.
// Reset clears the control state, the chain and the output valid; the key RAM
// needs no clearing. The input is taken while a result waits in the output
// register; a finished block waits until that register is free.
module aes_cbc_block_cipher_core #(
   parameter int KeyBits = acbc_pkg::KeyBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // data_high [63:0], data_low [127:64]
   input  logic         req_tuser,   // first_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_high [63:0], result_low [127:64]
   input  logic         csr_wr_en,
   input  logic [acbc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [acbc_pkg::CsrDataWidth-1:0] csr_wdata
);
   localparam int Nk     = KeyBits / 32;
   localparam int Nr     = Nk + 6;
   localparam int NWords = 4 * (Nr + 1);
   localparam int Depth  = 2 * (Nr + 1);
   localparam int AW     = $clog2(Depth);
   localparam int WW     = $clog2(NWords + 1);
   localparam int RW     = $clog2(Nr + 2);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_KLOAD = 3'd1;
   localparam logic [2:0] ST_KEXP  = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // configuration
   logic [63:0] key_ff [4];
   logic [63:0] iv_hi_ff, iv_lo_ff;
   logic        dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         iv_hi_ff <= '0;
         iv_lo_ff <= '0;
         dec_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            acbc_pkg::CSR_KEY0:    key_ff[0] <= csr_wdata;
            acbc_pkg::CSR_KEY1:    key_ff[1] <= csr_wdata;
            acbc_pkg::CSR_KEY2:    key_ff[2] <= csr_wdata;
            acbc_pkg::CSR_KEY3:    key_ff[3] <= csr_wdata;
            acbc_pkg::CSR_IV_HI:   iv_hi_ff  <= csr_wdata;
            acbc_pkg::CSR_IV_LO:   iv_lo_ff  <= csr_wdata;
            acbc_pkg::CSR_DECRYPT: dec_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control state
   logic [2:0]  state_ff, state_in;
   logic [WW-1:0] widx_ff, widx_in;     // key word being produced
   logic [2:0]  kpos_ff, kpos_in;       // position of that word within a key length
   logic [RW-1:0] rnd_ff, rnd_in;       // rounds done
   logic [7:0]  rcon_ff, rcon_in;
   logic        dec_op_ff, dec_op_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] blk_ff, blk_in;        // accepted input block
   logic [127:0] chain_ff, chain_in;
   logic [127:0] out_ff, out_in;
   logic        out_vld_ff, out_vld_in;
   // sliding window of the last Nk expanded words, newest in slot 0
   logic [31:0] win_ff [8];
   logic [31:0] win_in [8];
   // round key assembled from two RAM reads
   logic [63:0] rk_hi_ff, rk_hi_in;
   logic        half_ff, half_in;

   logic        ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [63:0] ram_wdata, ram_rdata;
   logic [31:0] pend_ff, pend_in;       // even word waiting for its odd partner

   acbc_key_ram #(.Depth(Depth)) u_key_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   logic [31:0] tw, nw;
   logic [127:0] rk;
   logic [127:0] enc_o, dec_o;
   logic [RW-1:0] key_rnd;

   always_comb begin
      state_in  = state_ff;
      widx_in   = widx_ff;
      kpos_in   = kpos_ff;
      rnd_in    = rnd_ff;
      rcon_in   = rcon_ff;
      dec_op_in = dec_op_ff;
      st_in     = st_ff;
      blk_in    = blk_ff;
      chain_in  = chain_ff;
      out_in    = out_ff;
      // drop the valid once the result has been handed over
      out_vld_in = out_vld_ff & ~rsp_tready;
      rk_hi_in  = rk_hi_ff;
      half_in   = half_ff;
      pend_in   = pend_ff;
      for (int i = 0; i < 8; i++) win_in[i] = win_ff[i];
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      tw = win_ff[0];
      nw = '0;
      rk = {rk_hi_ff, ram_rdata};
      enc_o = acbc_pkg::enc_round(st_ff, rnd_ff == RW'(Nr));
      dec_o = acbc_pkg::inv_shift_sub(st_ff) ^ rk;
      key_rnd = dec_op_ff ? RW'(Nr) - rnd_ff : rnd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dec_op_in = dec_ff;
               blk_in    = {req_tdata[63:0], req_tdata[127:64]};
               if (req_tuser) chain_in = {iv_hi_ff, iv_lo_ff};
               widx_in   = '0;
               kpos_in   = '0;
               rcon_in   = 8'h01;
               state_in  = req_tuser ? ST_KLOAD : ST_RUN;
               rnd_in    = '0;
               half_in   = 1'b0;
            end
         end
         ST_KLOAD: begin
            // copy the key words, one 64-bit word per cycle
            ram_we    = 1'b1;
            ram_waddr = AW'(widx_ff >> 1);
            ram_wdata = key_ff[widx_ff[2:1]];
            for (int i = 7; i >= 2; i--) win_in[i] = win_ff[i-2];
            win_in[1] = key_ff[widx_ff[2:1]][63:32];
            win_in[0] = key_ff[widx_ff[2:1]][31:0];
            widx_in   = widx_ff + WW'(2);
            if (widx_ff + WW'(2) == WW'(Nk)) state_in = ST_KEXP;
         end
         ST_KEXP: begin
            if (kpos_ff == '0) begin
               tw = acbc_pkg::sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^
                    {rcon_ff, 24'h0};
               rcon_in = acbc_pkg::xt(rcon_ff);
            end else if (Nk > 6 && kpos_ff == 3'd4) begin
               tw = acbc_pkg::sub_word(win_ff[0]);
            end
            nw = win_ff[Nk-1] ^ tw;
            for (int i = 7; i >= 1; i--) win_in[i] = win_ff[i-1];
            win_in[0] = nw;
            if (widx_ff[0]) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(widx_ff >> 1);
               ram_wdata = {pend_ff, nw};
            end else begin
               pend_in = nw;
            end
            widx_in = widx_ff + WW'(1);
            kpos_in = (kpos_ff == 3'(Nk - 1)) ? '0 : kpos_ff + 3'd1;
            if (widx_ff == WW'(NWords - 1)) state_in = ST_RUN;
         end
         ST_RUN: begin
            // half 0: issue the high read; half 1: issue the low read, take the high word
            if (!half_ff) begin
               ram_raddr = AW'({key_rnd, 1'b0});
               half_in   = 1'b1;
               widx_in   = '0;
            end else begin
               ram_raddr = AW'({key_rnd, 1'b1});
               rk_hi_in  = ram_rdata;
               half_in   = 1'b0;
               widx_in   = WW'(1);
            end
            // the low word lands in a half-0 cycle that follows a half-1 cycle
            if (!half_ff && widx_ff == WW'(1)) begin
               // low word of this round arrived; rk_hi_ff holds the high word
               if (rnd_ff == '0) begin
                  st_in = dec_op_ff ? (blk_ff ^ rk) : (blk_ff ^ chain_ff ^ rk);
               end else if (!dec_op_ff) begin
                  st_in = enc_o ^ rk;
               end else if (rnd_ff == RW'(Nr)) begin
                  st_in = dec_o ^ chain_ff;
               end else begin
                  st_in = acbc_pkg::inv_mix(dec_o);
               end
               if (rnd_ff == RW'(Nr)) begin
                  state_in = ST_DONE;
                  chain_in = dec_op_ff ? blk_ff : (enc_o ^ rk);
               end else begin
                  ram_raddr = AW'({dec_op_ff ? RW'(Nr) - rnd_ff - RW'(1)
                                             : rnd_ff + RW'(1), 1'b0});
               end
               rnd_in = rnd_ff + RW'(1);
            end
         end
         ST_DONE: begin
            // move the result into the output register once it is free
            if (!out_vld_ff || rsp_tready) begin
               out_in     = {st_ff[63:0], st_ff[127:64]};
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chain_ff   <= '0;
         widx_ff    <= '0;
         rnd_ff     <= '0;
         half_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         widx_ff    <= widx_in;
         rnd_ff     <= rnd_in;
         half_ff    <= half_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rcon_ff   <= rcon_in;
      kpos_ff   <= kpos_in;
      dec_op_ff <= dec_op_in;
      st_ff     <= st_in;
      blk_ff    <= blk_in;
      out_ff    <= out_in;
      rk_hi_ff  <= rk_hi_in;
      pend_ff   <= pend_in;
      for (int i = 0; i < 8; i++) win_ff[i] <= win_in[i];
   end

   ap_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   ap_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second block taken while one is in flight");
   ap_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_DONE)
      else $error("result without round pass");
endmodule

@@ hdl/acbc_key_ram.sv @@
// Round-key store: synchronous single-port write, one registered read port.
// Uses nothing from acbc_pkg.
module acbc_key_ram #(
   parameter int Depth = 30
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(Depth)-1:0]  wr_addr,
   input  logic [63:0]               wr_data,
   input  logic [$clog2(Depth)-1:0]  rd_addr,
   output logic [63:0]               rd_data
);
   logic [63:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
